[sv/pmvg_pkg.sv]
// shared types, constants and the marker command table of the point marker generator
package pmvg_pkg;

   // field and register widths
   localparam int COORD_BITS     = 14;
   localparam int TIC_BITS       = 10;
   localparam int HALF_BITS      = TIC_BITS - 1;
   localparam int OFF_BITS       = TIC_BITS;
   localparam int MARK_BITS      = 8;
   localparam int STEP_BITS      = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 14;

   // job queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   // divide by three: (n * 2731) >> 13, exact for n below 8192
   localparam int RECIP3_BITS  = 12;
   localparam int RECIP3       = 2731;
   localparam int RECIP3_SHIFT = 13;
   localparam int PROD3_BITS   = HALF_BITS + 2 + RECIP3_BITS;

   // divide by six: (m * 171) >> 10, exact for m below 512
   localparam int RECIP6       = 171;
   localparam int RECIP6_SHIFT = 10;
   localparam int PROD6_BITS   = 2 * MARK_BITS;
   localparam int QUOT6_BITS   = PROD6_BITS - RECIP6_SHIFT;

   // register reset values
   localparam logic [TIC_BITS-1:0]   HORIZ_TIC_RESET = TIC_BITS'(8);
   localparam logic [TIC_BITS-1:0]   VERT_TIC_RESET  = TIC_BITS'(8);
   localparam logic [COORD_BITS-1:0] X_EXTENT_RESET  = COORD_BITS'(1024);
   localparam logic [COORD_BITS-1:0] Y_EXTENT_RESET  = COORD_BITS'(780);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HORIZ_TIC = 2'd0,
      CSR_VERT_TIC  = 2'd1,
      CSR_X_EXTENT  = 2'd2,
      CSR_Y_EXTENT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      SHAPE_DIAMOND  = 3'd0,
      SHAPE_PLUS     = 3'd1,
      SHAPE_BOX      = 3'd2,
      SHAPE_CROSS    = 3'd3,
      SHAPE_TRIANGLE = 3'd4,
      SHAPE_STAR     = 3'd5
   } shape_type;

   typedef enum logic {
      CMD_MOVE = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_kind_type;

   typedef enum logic [2:0] {
      XS_CENTER   = 3'd0,
      XS_MINUS_H  = 3'd1,
      XS_PLUS_H   = 3'd2,
      XS_MINUS_H4 = 3'd3,
      XS_PLUS_H4  = 3'd4
   } xsel_type;

   typedef enum logic [2:0] {
      YS_CENTER   = 3'd0,
      YS_MINUS_V  = 3'd1,
      YS_PLUS_V   = 3'd2,
      YS_PLUS_V4  = 3'd3,
      YS_MINUS_V2 = 3'd4
   } ysel_type;

   typedef struct packed {
      cmd_kind_type kind;
      xsel_type     xsel;
      ysel_type     ysel;
      logic         last;
   } step_cmd_type;

   typedef struct packed {
      logic [TIC_BITS-1:0]   horiz_tic;
      logic [TIC_BITS-1:0]   vert_tic;
      logic [COORD_BITS-1:0] x_extent;
      logic [COORD_BITS-1:0] y_extent;
   } cfg_type;

   // one classified marker waiting for the back end
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      shape_type             shape;
      logic [OFF_BITS-1:0]   h;
      logic [OFF_BITS-1:0]   v;
      logic [OFF_BITS-1:0]   h4;
      logic [OFF_BITS-1:0]   v4;
      logic [OFF_BITS-1:0]   v2;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                 busy;
      logic [STEP_BITS-1:0] step;
   } back_status_type;

   function automatic step_cmd_type mk_cmd(cmd_kind_type kind, xsel_type xs, ysel_type ys,
                                           logic last);
      step_cmd_type c;
      c.kind = kind;
      c.xsel = xs;
      c.ysel = ys;
      c.last = last;
      return c;
   endfunction

   // pen command of one step of one shape
   function automatic step_cmd_type step_cmd(shape_type shape, logic [STEP_BITS-1:0] step);
      step_cmd_type c;
      c = mk_cmd(CMD_DRAW, XS_CENTER, YS_CENTER, 1'b1);
      case (shape)
         SHAPE_DIAMOND: begin
            case (step)
               3'd0: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_CENTER, 1'b0);
               3'd1: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_MINUS_V, 1'b0);
               3'd2: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_CENTER, 1'b0);
               3'd3: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_PLUS_V, 1'b0);
               3'd4: c = mk_cmd(CMD_DRAW, XS_MINUS_H, YS_CENTER, 1'b0);
               3'd5: c = mk_cmd(CMD_MOVE, XS_CENTER, YS_CENTER, 1'b0);
               default: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_CENTER, 1'b1);
            endcase
         end
         SHAPE_PLUS: begin
            case (step)
               3'd0: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_CENTER, 1'b0);
               3'd1: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_CENTER, 1'b0);
               3'd2: c = mk_cmd(CMD_MOVE, XS_CENTER, YS_MINUS_V, 1'b0);
               default: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_PLUS_V, 1'b1);
            endcase
         end
         SHAPE_BOX: begin
            case (step)
               3'd0: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_MINUS_V, 1'b0);
               3'd1: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_MINUS_V, 1'b0);
               3'd2: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_PLUS_V, 1'b0);
               3'd3: c = mk_cmd(CMD_DRAW, XS_MINUS_H, YS_PLUS_V, 1'b0);
               3'd4: c = mk_cmd(CMD_DRAW, XS_MINUS_H, YS_MINUS_V, 1'b0);
               3'd5: c = mk_cmd(CMD_MOVE, XS_CENTER, YS_CENTER, 1'b0);
               default: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_CENTER, 1'b1);
            endcase
         end
         SHAPE_CROSS: begin
            case (step)
               3'd0: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_MINUS_V, 1'b0);
               3'd1: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_PLUS_V, 1'b0);
               3'd2: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_PLUS_V, 1'b0);
               default: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_MINUS_V, 1'b1);
            endcase
         end
         SHAPE_TRIANGLE: begin
            case (step)
               3'd0: c = mk_cmd(CMD_MOVE, XS_CENTER, YS_PLUS_V4, 1'b0);
               3'd1: c = mk_cmd(CMD_DRAW, XS_MINUS_H4, YS_MINUS_V2, 1'b0);
               3'd2: c = mk_cmd(CMD_DRAW, XS_PLUS_H4, YS_MINUS_V2, 1'b0);
               3'd3: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_PLUS_V4, 1'b0);
               3'd4: c = mk_cmd(CMD_MOVE, XS_CENTER, YS_CENTER, 1'b0);
               default: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_CENTER, 1'b1);
            endcase
         end
         default: begin
            // star: plus followed by cross
            case (step)
               3'd0: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_CENTER, 1'b0);
               3'd1: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_CENTER, 1'b0);
               3'd2: c = mk_cmd(CMD_MOVE, XS_CENTER, YS_MINUS_V, 1'b0);
               3'd3: c = mk_cmd(CMD_DRAW, XS_CENTER, YS_PLUS_V, 1'b0);
               3'd4: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_MINUS_V, 1'b0);
               3'd5: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_PLUS_V, 1'b0);
               3'd6: c = mk_cmd(CMD_MOVE, XS_MINUS_H, YS_PLUS_V, 1'b0);
               default: c = mk_cmd(CMD_DRAW, XS_PLUS_H, YS_MINUS_V, 1'b1);
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

[sv/pmvg_req_if.sv]
// point request channel: valid, ready and one point with its marker number
interface pmvg_req_if import pmvg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic [MARK_BITS-1:0]  marker_number;

   modport source (output valid, point_x, point_y, marker_number, input ready);
   modport sink (input valid, point_x, point_y, marker_number, output ready);
endinterface

[sv/pmvg_rsp_if.sv]
// pen command channel: valid, ready and one pen command
interface pmvg_rsp_if import pmvg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  command_kind;
   logic [COORD_BITS-1:0] target_x;
   logic [COORD_BITS-1:0] target_y;
   logic                  last_command;

   modport source (output valid, command_kind, target_x, target_y, last_command, input ready);
   modport sink (input valid, command_kind, target_x, target_y, last_command, output ready);
endinterface

[sv/pmvg_front.sv]
// front end: border rejection, shape selection and marker offsets for each point
module pmvg_front import pmvg_pkg::*; (
   pmvg_req_if.sink         req_chan,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   logic [HALF_BITS-1:0]    half_h;
   logic [HALF_BITS-1:0]    half_v;
   logic [HALF_BITS+1:0]    quad_h;
   logic [HALF_BITS+1:0]    quad_v;
   logic [HALF_BITS+1:0]    dbl_v;
   logic [PROD3_BITS-1:0]   prod_h4;
   logic [PROD3_BITS-1:0]   prod_v4;
   logic [PROD3_BITS-1:0]   prod_v2;
   logic [PROD6_BITS-1:0]   prod6;
   logic [QUOT6_BITS-1:0]   quot6;
   logic [MARK_BITS-1:0]    rem6;
   logic [COORD_BITS:0]     x_limit;
   logic [COORD_BITS:0]     y_limit;
   logic                    reject;

   // half tics and the triangle offsets
   assign half_h  = cfg.horiz_tic[TIC_BITS-1:1];
   assign half_v  = cfg.vert_tic[TIC_BITS-1:1];
   assign quad_h  = {half_h, 2'b00};
   assign quad_v  = {half_v, 2'b00};
   assign dbl_v   = {1'b0, half_v, 1'b0};
   assign prod_h4 = PROD3_BITS'(quad_h) * PROD3_BITS'(RECIP3);
   assign prod_v4 = PROD3_BITS'(quad_v) * PROD3_BITS'(RECIP3);
   assign prod_v2 = PROD3_BITS'(dbl_v) * PROD3_BITS'(RECIP3);

   // marker number mod six
   assign prod6 = PROD6_BITS'(req_chan.marker_number) * PROD6_BITS'(RECIP6);
   assign quot6 = prod6[PROD6_BITS-1:RECIP6_SHIFT];
   assign rem6  = req_chan.marker_number
                - (MARK_BITS'({quot6, 2'b00}) + MARK_BITS'({quot6, 1'b0}));

   // border rejection, upper limits taken as signed
   assign x_limit = {1'b0, cfg.x_extent} - (COORD_BITS+1)'(cfg.horiz_tic);
   assign y_limit = {1'b0, cfg.y_extent} - (COORD_BITS+1)'(cfg.vert_tic);
   assign reject  = (req_chan.point_x < COORD_BITS'(cfg.horiz_tic))
                 || (req_chan.point_y < COORD_BITS'(cfg.vert_tic))
                 || ($signed({1'b0, req_chan.point_x}) >= $signed(x_limit))
                 || ($signed({1'b0, req_chan.point_y}) >= $signed(y_limit));

   // rejected points are taken and dropped
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full && !reject;

   always_comb begin
      push_job.x     = req_chan.point_x;
      push_job.y     = req_chan.point_y;
      push_job.shape = shape_type'(rem6[2:0]);
      push_job.h     = OFF_BITS'(half_h);
      push_job.v     = OFF_BITS'(half_v);
      push_job.h4    = OFF_BITS'(prod_h4 >> RECIP3_SHIFT);
      push_job.v4    = OFF_BITS'(prod_v4 >> RECIP3_SHIFT);
      push_job.v2    = OFF_BITS'(prod_v2 >> RECIP3_SHIFT);
   end

endmodule

[sv/pmvg_queue.sv]
// short job queue between front end and back end
module pmvg_queue import pmvg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job       = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

endmodule

[sv/pmvg_back.sv]
// back end: steps through the shape's pen commands into the result register
module pmvg_back import pmvg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   output back_status_type  back_status,
   pmvg_rsp_if.source       rsp_chan
);

   logic [STEP_BITS-1:0]  step_ff;
   logic [STEP_BITS-1:0]  step_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  kind_ff;
   logic [COORD_BITS-1:0] target_x_ff;
   logic [COORD_BITS-1:0] target_x_in;
   logic [COORD_BITS-1:0] target_y_ff;
   logic [COORD_BITS-1:0] target_y_in;
   logic                  last_ff;
   logic                  load;
   logic                  emit;
   step_cmd_type          cmd;
   logic [OFF_BITS-1:0]   off_x;
   logic [OFF_BITS-1:0]   off_y;
   logic                  sub_x;
   logic                  sub_y;

   assign load = !valid_ff || rsp_chan.ready;
   assign emit = !q_status.empty && load;
   assign cmd  = step_cmd(head_job.shape, step_ff);
   assign pop  = emit && cmd.last;

   // offset selection for x
   always_comb begin
      off_x = '0;
      sub_x = 1'b0;
      case (cmd.xsel)
         XS_MINUS_H: begin
            off_x = head_job.h;
            sub_x = 1'b1;
         end
         XS_PLUS_H: begin
            off_x = head_job.h;
         end
         XS_MINUS_H4: begin
            off_x = head_job.h4;
            sub_x = 1'b1;
         end
         XS_PLUS_H4: begin
            off_x = head_job.h4;
         end
         default: begin
            off_x = '0;
         end
      endcase
   end

   // offset selection for y
   always_comb begin
      off_y = '0;
      sub_y = 1'b0;
      case (cmd.ysel)
         YS_MINUS_V: begin
            off_y = head_job.v;
            sub_y = 1'b1;
         end
         YS_PLUS_V: begin
            off_y = head_job.v;
         end
         YS_PLUS_V4: begin
            off_y = head_job.v4;
         end
         YS_MINUS_V2: begin
            off_y = head_job.v2;
            sub_y = 1'b1;
         end
         default: begin
            off_y = '0;
         end
      endcase
   end

   // command end point
   assign target_x_in = sub_x ? head_job.x - COORD_BITS'(off_x)
                              : head_job.x + COORD_BITS'(off_x);
   assign target_y_in = sub_y ? head_job.y - COORD_BITS'(off_y)
                              : head_job.y + COORD_BITS'(off_y);

   // step counter and result valid
   always_comb begin
      step_in = step_ff;
      if (pop) begin
         step_in = '0;
      end else if (emit) begin
         step_in = step_ff + STEP_BITS'(1);
      end
      valid_in = emit ? 1'b1 : (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff     <= cmd.kind;
         target_x_ff <= target_x_in;
         target_y_ff <= target_y_in;
         last_ff     <= cmd.last;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.command_kind = kind_ff;
   assign rsp_chan.target_x     = target_x_ff;
   assign rsp_chan.target_y     = target_y_ff;
   assign rsp_chan.last_command = last_ff;

   assign back_status.busy = !q_status.empty;
   assign back_status.step = step_ff;

endmodule

[sv/point_marker_vector_generator.sv]
// Point marker generator top level: configuration registers, front end, job queue, back end.
// Each accepted point either falls within one tic of a border and yields no words, or
// yields the pen commands of its marker: 4 words for plus and X, 6 for the triangle,
// 7 for diamond and box, 8 for the star, the last one flagged with last_command. The
// back end writes one word per cycle into a single result register while the receiver
// is ready; a rejected point is taken at the input and dropped. Points are taken every
// cycle while the two-entry job queue has room, so the front end keeps accepting while
// the back end drains a marker.
module point_marker_vector_generator import pmvg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   pmvg_req_if.sink                  req_chan,
   pmvg_rsp_if.source                rsp_chan
);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_status_type q_status;
   back_status_type  back_status;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HORIZ_TIC: cfg_in.horiz_tic = csr_wdata[TIC_BITS-1:0];
            CSR_VERT_TIC:  cfg_in.vert_tic  = csr_wdata[TIC_BITS-1:0];
            CSR_X_EXTENT:  cfg_in.x_extent  = csr_wdata[COORD_BITS-1:0];
            CSR_Y_EXTENT:  cfg_in.y_extent  = csr_wdata[COORD_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horiz_tic <= HORIZ_TIC_RESET;
         cfg_ff.vert_tic  <= VERT_TIC_RESET;
         cfg_ff.x_extent  <= X_EXTENT_RESET;
         cfg_ff.y_extent  <= Y_EXTENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pmvg_front u_front (
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   pmvg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   pmvg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .pop         (pop),
      .back_status (back_status),
      .rsp_chan    (rsp_chan)
   );

   // step counter is back at the first command whenever no job is waiting
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (back_status.step == '0))
      else $error("marker step counter not cleared with empty queue");

   // no result word right after reset
   a_out_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_chan.valid)
      else $error("result word valid right after reset");

   // a job pushed into an empty queue makes the back end busy next cycle
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      (push && q_status.empty) |=> back_status.busy)
      else $error("pushed job not visible to back end");

endmodule
